FILE: sv/vrefr_pkg.sv
// ---------------------------------------------------------------------------
// vrefr_pkg
// Shared types and constants of the refraction pipeline.
// ---------------------------------------------------------------------------
package vrefr_pkg;

    // fixed width of the refractive index fields, Q3.13
    localparam int INDEX_BITS = 16;
    localparam int ETA_FRAC   = 13;
    localparam int ETA_MAX    = 65535;

    // quotient stages: one bit of the quotient per stage
    localparam int QUOT_BITS  = 30;

    // flags that travel with an item
    typedef struct packed {
        logic valid;
        logic index_error;
    } vrefr_ctl_t;

endpackage

FILE: sv/vrefr_div.sv
// ---------------------------------------------------------------------------
// vrefr_div
// Pipelined restoring divider for eta = index_from * 2^13 / index_to.
// ---------------------------------------------------------------------------
module vrefr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic        out_valid,
    output logic [15:0] eta
);

    localparam int NB = vrefr_pkg::QUOT_BITS;

    // per-stage remainder, quotient, dividend, divisor and valid bit
    logic [NB-1:0] valid_reg;
    logic [16:0]   rem_reg [NB];
    logic [NB-1:0] quo_reg [NB];
    logic [15:0]   den_reg [NB];
    logic [NB-1:0] num_reg [NB];

    // dividend held as 30 bits: num shifted by 13, fed one bit a stage
    logic [NB-1:0] dividend;
    assign dividend = {1'b0, num, 13'd0};

    genvar g;
    generate
        for (g = 0; g < NB; g++)
        begin : g_stage
            logic          v_in;
            logic [16:0]   rem_in;
            logic [NB-1:0] quo_in;
            logic [NB-1:0] num_in;
            logic [15:0]   den_in;
            logic [17:0]   trial;
            logic [17:0]   diff;
            if (g == 0)
            begin : g_first
                assign v_in   = in_valid;
                assign rem_in = '0;
                assign quo_in = '0;
                assign num_in = dividend;
                assign den_in = den;
            end
            else
            begin : g_next
                assign v_in   = valid_reg[g-1];
                assign rem_in = rem_reg[g-1];
                assign quo_in = quo_reg[g-1];
                assign num_in = num_reg[g-1];
                assign den_in = den_reg[g-1];
            end
            // shift in the next dividend bit, trial subtract
            assign trial = {rem_in, num_in[NB-1-g]};
            assign diff  = trial - {2'b00, den_in};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else
                begin
                    valid_reg[g] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (!diff[17])
                begin
                    rem_reg[g] <= diff[16:0];
                end
                else
                begin
                    rem_reg[g] <= trial[16:0];
                end
                quo_reg[g] <= {quo_in[NB-2:0], ~diff[17]};
                num_reg[g] <= num_in;
                den_reg[g] <= den_in;
            end
        end
    endgenerate

    // saturate the quotient to the eta range
    assign out_valid = valid_reg[NB-1];
    assign eta = (quo_reg[NB-1] > NB'(vrefr_pkg::ETA_MAX)) ? 16'hFFFF
                                                            : quo_reg[NB-1][15:0];

endmodule

FILE: sv/vrefr_sqrt.sv
// ---------------------------------------------------------------------------
// vrefr_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module vrefr_sqrt #(
    parameter int XW = 34
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [XW-1:0]     x,
    output logic              out_valid,
    output logic [XW/2-1:0]   root
);

    localparam int RW = XW / 2;

    logic [RW-1:0] valid_reg;
    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [XW-1:0] x_reg    [RW];

    genvar g;
    generate
        for (g = 0; g < RW; g++)
        begin : g_stage
            logic          v_in;
            logic [RW+1:0] rem_in;
            logic [RW-1:0] root_in;
            logic [XW-1:0] x_in;
            logic [RW+3:0] cur;
            logic [RW+3:0] trial;
            if (g == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = x;
            end
            else
            begin : g_next
                assign v_in    = valid_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign x_in    = x_reg[g-1];
            end
            // bring down two bits, try (root << 2) | 1
            assign cur   = {rem_in, x_in[XW-1-2*g -: 2]};
            assign trial = {root_in, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else
                begin
                    valid_reg[g] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (cur >= trial)
                begin
                    rem_reg[g]  <= (RW+2)'(cur - trial);
                    root_reg[g] <= {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g]  <= cur[RW+1:0];
                    root_reg[g] <= {root_in[RW-2:0], 1'b0};
                end
                x_reg[g] <= x_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];

endmodule

FILE: sv/vector_refraction.sv
// ---------------------------------------------------------------------------
// vector_refraction
// Snell refraction of a 2D direction at a surface, fully pipelined.
// ---------------------------------------------------------------------------
// pipeline: 30 divider stages, COMPONENT_BITS + 1 root stages and five arithmetic
//   stages (A to E) lie between the accepting edge and done
// throughput: one item per cycle, busy stays low; set by the bit-per-stage
//   divider and root pipelines
// reset: asynchronous active low, clears all valid bits, no result pending
// the receiver cannot stall, so done is shown for exactly one cycle
module vector_refraction #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COMPONENT_BITS-1:0] dir_x,
    input  logic signed [COMPONENT_BITS-1:0] dir_y,
    input  logic signed [COMPONENT_BITS-1:0] normal_x,
    input  logic signed [COMPONENT_BITS-1:0] normal_y,
    input  logic [15:0]                      index_from,
    input  logic [15:0]                      index_to,
    output logic                             done,
    output logic signed [COMPONENT_BITS-1:0] out_x,
    output logic signed [COMPONENT_BITS-1:0] out_y,
    output logic                             total_reflection,
    output logic                             index_error
);

    localparam int C    = COMPONENT_BITS;
    localparam int F    = C - 2;
    localparam int DIVL = vrefr_pkg::QUOT_BITS;
    localparam int XW   = 2 * F + 6;
    localparam int RW   = XW / 2;
    localparam int SQL  = RW;
    localparam int LAT  = DIVL + SQL + 4;
    localparam int WW   = 2 * C + 20;

    localparam logic signed [WW-1:0] ONE_Q   = WW'(64'sd1 <<< F);
    localparam logic signed [WW-1:0] D_LIM   = WW'((64'sd1 <<< (F + 2)) - 1);
    localparam logic signed [WW-1:0] K_LIM   = WW'((64'sd1 <<< (F + 4)) - 1);
    localparam logic signed [WW-1:0] CMAX    = WW'((64'sd1 <<< (C - 1)) - 1);
    localparam logic signed [WW-1:0] CMIN    = WW'(-(64'sd1 <<< (C - 1)));

    assign busy = 1'b0;

    logic item_in;
    assign item_in = start && !busy;

    // ---- delay lines for operands alongside the divider ----
    logic signed [C-1:0] ix_reg [LAT];
    logic signed [C-1:0] iy_reg [LAT];
    logic signed [C-1:0] nx_reg [LAT];
    logic signed [C-1:0] ny_reg [LAT];
    logic [LAT-1:0]      err_reg;

    always_ff @(posedge clk)
    begin
        ix_reg[0] <= dir_x;
        iy_reg[0] <= dir_y;
        nx_reg[0] <= normal_x;
        ny_reg[0] <= normal_y;
        err_reg[0] <= (index_to == 16'd0);
        for (int j = 1; j < LAT; j++)
        begin
            ix_reg[j]  <= ix_reg[j-1];
            iy_reg[j]  <= iy_reg[j-1];
            nx_reg[j]  <= nx_reg[j-1];
            ny_reg[j]  <= ny_reg[j-1];
            err_reg[j] <= err_reg[j-1];
        end
    end

    // ---- divider ----
    logic        div_valid;
    logic [15:0] eta_div;

    vrefr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in),
        .num       (index_from),
        .den       (index_to),
        .out_valid (div_valid),
        .eta       (eta_div)
    );

    // ---- stage A: products for d, eta^2 ----
    localparam int PA = DIVL - 1;
    logic                  a_valid_reg;
    logic signed [WW-1:0]  a_px_reg;
    logic signed [WW-1:0]  a_py_reg;
    logic [31:0]           a_e2_reg;
    logic [15:0]           a_eta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_px_reg  <= WW'(ix_reg[PA] * nx_reg[PA]) >>> F;
        a_py_reg  <= WW'(iy_reg[PA] * ny_reg[PA]) >>> F;
        a_e2_reg  <= (32'(eta_div) * 32'(eta_div)) >> vrefr_pkg::ETA_FRAC;
        a_eta_reg <= eta_div;
    end

    // ---- stage B: d clamp and m ----
    // |d| is clamped below 2^C, so its magnitude fits C bits
    logic signed [WW-1:0] d_sum;
    logic signed [WW-1:0] d_cl;
    logic [C-1:0]         ad;
    assign d_sum = a_px_reg + a_py_reg;
    assign d_cl  = (d_sum > D_LIM) ? D_LIM : ((d_sum < -D_LIM) ? -D_LIM : d_sum);
    assign ad    = C'(d_cl[WW-1] ? -d_cl : d_cl);

    logic                 b_valid_reg;
    logic signed [WW-1:0] b_m_reg;
    logic signed [WW-1:0] b_d_reg;
    logic [31:0]          b_e2_reg;
    logic [15:0]          b_eta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_m_reg   <= ONE_Q - WW'((ad * ad) >> F);
        b_d_reg   <= d_cl;
        b_e2_reg  <= a_e2_reg;
        b_eta_reg <= a_eta_reg;
    end

    // ---- stage C: k ----
    // m lies in [-2^(C+2), 2^F], so C+3 signed bits carry it
    logic signed [WW+33:0] e2m;
    assign e2m = $signed({1'b0, b_e2_reg}) * $signed(b_m_reg[C+2:0]);

    logic                 c_valid_reg;
    logic signed [WW-1:0] c_k_reg;
    logic signed [WW-1:0] c_d_reg;
    logic [15:0]          c_eta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_k_reg   <= ONE_Q - WW'(e2m >>> vrefr_pkg::ETA_FRAC);
        c_d_reg   <= b_d_reg;
        c_eta_reg <= b_eta_reg;
    end

    // ---- square root of saturated k << F ----
    logic          tir_now;
    logic [WW-1:0] k_sat;
    logic [XW-1:0] sq_x;
    assign tir_now = c_k_reg[WW-1];
    assign k_sat   = tir_now ? '0 : ((c_k_reg > K_LIM) ? K_LIM : c_k_reg);
    assign sq_x    = XW'(k_sat) << F;

    logic          sq_valid;
    logic [RW-1:0] sq_root;

    vrefr_sqrt #(.XW(XW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .x         (sq_x),
        .out_valid (sq_valid),
        .root      (sq_root)
    );

    // side delay for d, eta, tir through the root pipeline
    logic signed [WW-1:0] s_d_reg   [SQL];
    logic [15:0]          s_eta_reg [SQL];
    logic [SQL-1:0]       s_tir_reg;

    always_ff @(posedge clk)
    begin
        s_d_reg[0]   <= c_d_reg;
        s_eta_reg[0] <= c_eta_reg;
        s_tir_reg[0] <= tir_now;
        for (int j = 1; j < SQL; j++)
        begin
            s_d_reg[j]   <= s_d_reg[j-1];
            s_eta_reg[j] <= s_eta_reg[j-1];
            s_tir_reg[j] <= s_tir_reg[j-1];
        end
    end

    // ---- stage D: c = eta*d/2^13 + s, eta*i ----
    localparam int PD = DIVL + 2 + SQL;
    logic                 d_valid_reg;
    logic signed [WW-1:0] d_c_reg;
    logic signed [WW-1:0] d_ex_reg;
    logic signed [WW-1:0] d_ey_reg;
    logic                 d_tir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_c_reg  <= WW'(($signed({1'b0, s_eta_reg[SQL-1]}) * $signed(s_d_reg[SQL-1][C:0]))
                        >>> vrefr_pkg::ETA_FRAC) + WW'(sq_root);
        d_ex_reg <= WW'(($signed({1'b0, s_eta_reg[SQL-1]}) * ix_reg[PD])
                        >>> vrefr_pkg::ETA_FRAC);
        d_ey_reg <= WW'(($signed({1'b0, s_eta_reg[SQL-1]}) * iy_reg[PD])
                        >>> vrefr_pkg::ETA_FRAC);
        d_tir_reg <= s_tir_reg[SQL-1];
    end

    // ---- stage E: subtract c*n, saturate ----
    // |c| stays below 2^(C+4), so C+5 signed bits carry it
    localparam int PE = PD + 1;
    logic signed [WW-1:0] ox;
    logic signed [WW-1:0] oy;
    assign ox = d_ex_reg - WW'(($signed(d_c_reg[C+4:0]) * nx_reg[PE]) >>> F);
    assign oy = d_ey_reg - WW'(($signed(d_c_reg[C+4:0]) * ny_reg[PE]) >>> F);

    logic                 e_valid_reg;
    logic signed [C-1:0]  e_x_reg;
    logic signed [C-1:0]  e_y_reg;
    logic                 e_tir_reg;
    logic                 e_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_err_reg <= err_reg[PE];
        e_tir_reg <= d_tir_reg && !err_reg[PE];
        if (err_reg[PE] || d_tir_reg)
        begin
            e_x_reg <= '0;
            e_y_reg <= '0;
        end
        else
        begin
            e_x_reg <= (ox > CMAX) ? CMAX[C-1:0] : ((ox < CMIN) ? CMIN[C-1:0] : ox[C-1:0]);
            e_y_reg <= (oy > CMAX) ? CMAX[C-1:0] : ((oy < CMIN) ? CMIN[C-1:0] : oy[C-1:0]);
        end
    end

    assign done             = e_valid_reg;
    assign out_x            = e_x_reg;
    assign out_y            = e_y_reg;
    assign total_reflection = e_tir_reg;
    assign index_error      = e_err_reg;

endmodule

FILE: sv/vrefr_checker.sv
// ---------------------------------------------------------------------------
// vrefr_checker
// Port-level checks of the refraction block.
// ---------------------------------------------------------------------------
module vrefr_checker #(
    parameter int COMPONENT_BITS = 16
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [COMPONENT_BITS-1:0] out_x,
    input logic [COMPONENT_BITS-1:0] out_y,
    input logic                      total_reflection,
    input logic                      index_error
);

    // flags never both set
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(total_reflection && index_error))
        else $error("both flags set");

    // flagged items carry a zero vector
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (total_reflection || index_error)) |-> (out_x == '0 && out_y == '0))
        else $error("flagged item not zero");

    // the block always takes items
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // each accepted item shows its result after the fixed pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(COMPONENT_BITS + 36) done)
        else $error("result missing after latency");

    // no result right after reset release without input
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !done)
        else $error("result after reset");

endmodule

bind vector_refraction vrefr_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .out_x            (out_x),
    .out_y            (out_y),
    .total_reflection (total_reflection),
    .index_error      (index_error)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the refraction pipeline item by item against a fixed-point
// predictor: directed corner items, then random rays with random gaps.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CB        = 16;
    localparam int FB        = CB - 2;
    localparam int LATENCY   = CB + 36;
    localparam int MAX_CYC   = 200000;
    localparam int N_RANDOM  = 1600;

    typedef struct {
        logic signed [CB-1:0] ox;
        logic signed [CB-1:0] oy;
        logic                 tir;
        logic                 ierr;
    } ray_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CB-1:0] dir_x;
    logic signed [CB-1:0] dir_y;
    logic signed [CB-1:0] normal_x;
    logic signed [CB-1:0] normal_y;
    logic [15:0]          index_from;
    logic [15:0]          index_to;
    logic                 done;
    logic signed [CB-1:0] out_x;
    logic signed [CB-1:0] out_y;
    logic                 total_reflection;
    logic                 index_error;

    ray_result_t pending_rays[$];
    int          mismatches;
    int          cycles;
    int          idle_pct;

    vector_refraction #(.COMPONENT_BITS(CB)) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .dir_x            (dir_x),
        .dir_y            (dir_y),
        .normal_x         (normal_x),
        .normal_y         (normal_y),
        .index_from       (index_from),
        .index_to         (index_to),
        .done             (done),
        .out_x            (out_x),
        .out_y            (out_y),
        .total_reflection (total_reflection),
        .index_error      (index_error)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // floor division by a power of two (arithmetic shift)
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // digit-by-digit square root, 32 steps
    function automatic longint isqrt(longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        rem = 0;
        root = 0;
        for (int i = 0; i < 32; i++)
        begin
            rem = (rem << 2) | (x >> 62);
            x = x << 2;
            root = root << 1;
            if (rem >= ((root << 1) | 1))
            begin
                rem = rem - ((root << 1) | 1);
                root = root | 1;
            end
        end
        return longint'(root);
    endfunction

    // snell refraction of one ray
    function automatic ray_result_t refract_ray(longint ix, longint iy, longint nx,
                                               longint ny, longint efrom, longint eto);
        ray_result_t r;
        longint eta, d, ad, m, e2, k, s, c, ox, oy;
        r.ox = '0;
        r.oy = '0;
        r.tir = 1'b0;
        r.ierr = 1'b0;
        if (eto == 0)
        begin
            r.ierr = 1'b1;
            return r;
        end
        eta = (efrom << vrefr_pkg::ETA_FRAC) / eto;
        if (eta > vrefr_pkg::ETA_MAX)
            eta = vrefr_pkg::ETA_MAX;
        d = fshr(ix * nx, FB) + fshr(iy * ny, FB);
        d = clampv(d, -((64'sd1 << (FB + 2)) - 1), (64'sd1 << (FB + 2)) - 1);
        ad = (d < 0) ? -d : d;
        m = (64'sd1 << FB) - ((ad * ad) >> FB);
        e2 = (eta * eta) >> vrefr_pkg::ETA_FRAC;
        k = (64'sd1 << FB) - fshr(e2 * m, vrefr_pkg::ETA_FRAC);
        if (k < 0)
        begin
            r.tir = 1'b1;
            return r;
        end
        if (k > (64'sd1 << (FB + 4)) - 1)
            k = (64'sd1 << (FB + 4)) - 1;
        s = isqrt(longint'(k) << FB);
        c = fshr(eta * d, vrefr_pkg::ETA_FRAC) + s;
        // c stays below 2^38 and |n| is at most 2^15, so the product fits 64 bits
        ox = fshr(eta * ix, vrefr_pkg::ETA_FRAC) - fshr(c * nx, FB);
        oy = fshr(eta * iy, vrefr_pkg::ETA_FRAC) - fshr(c * ny, FB);
        r.ox = CB'(clampv(ox, -(64'sd1 << (CB - 1)), (64'sd1 << (CB - 1)) - 1));
        r.oy = CB'(clampv(oy, -(64'sd1 << (CB - 1)), (64'sd1 << (CB - 1)) - 1));
        return r;
    endfunction

    // send one item, predicting its result when accepted
    task automatic send_ray(logic signed [CB-1:0] ix, logic signed [CB-1:0] iy,
                            logic signed [CB-1:0] nx, logic signed [CB-1:0] ny,
                            logic [15:0] efrom, logic [15:0] eto);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        dir_x <= ix;
        dir_y <= iy;
        normal_x <= nx;
        normal_y <= ny;
        index_from <= efrom;
        index_to <= eto;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rays.push_back(refract_ray(ix, iy, nx, ny, efrom, eto));
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        go_idle();
        while (pending_rays.size() != 0)
            @(posedge clk);
    endtask

    // directed corners: extreme fields, zero indices, reflection, head-on
    task automatic test_directed();
        logic signed [CB-1:0] mx, mn, one;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        one = CB'(1 <<< FB);
        send_ray('0, -one, '0, one, 16'h2000, 16'h2000);
        send_ray('0, -one, '0, one, 16'h2000, 16'h2AAB);
        send_ray(one, '0, '0, one, 16'h3000, 16'h2000);
        send_ray(CB'(11585), CB'(-11585), '0, one, 16'h3000, 16'h2000);
        send_ray(CB'(11585), CB'(-11585), '0, one, 16'h2000, 16'h3000);
        send_ray(mx, mx, mx, mx, 16'hFFFF, 16'h0001);
        send_ray(mn, mn, mn, mn, 16'hFFFF, 16'hFFFF);
        send_ray(mx, mn, mn, mx, 16'h0001, 16'hFFFF);
        send_ray(mn, mx, mx, mn, 16'h2000, 16'h2000);
        send_ray(one, one, one, one, 16'h1234, 16'h0000);
        send_ray('0, '0, '0, '0, 16'h0000, 16'h0000);
        send_ray('0, '0, '0, '0, 16'h0000, 16'h2000);
        send_ray('1, '1, '1, '1, 16'hFFFF, 16'h0001);
        send_ray(one, -one, -one, one, 16'h0000, 16'h2000);
        send_ray(mx, '0, mn, '0, 16'h8000, 16'h4000);
    endtask

    // random rays: mostly bounded vectors with glass-like indices
    task automatic test_random(int count);
        int a, b;
        logic signed [CB-1:0] ix, iy, nx, ny;
        logic [15:0] ef, et;
        for (int i = 0; i < count; i++)
        begin
            idle_pct = (i >= 400 && i < 700) ? 0 : 14;
            if ($urandom_range(3) != 0)
            begin
                a = $urandom_range(23170);
                b = $urandom_range(23170);
                ix = CB'(($urandom_range(1)) ? a : -a);
                iy = CB'(($urandom_range(1)) ? b : -b);
                a = $urandom_range(16384);
                nx = CB'(($urandom_range(1)) ? a : -a);
                ny = CB'(($urandom_range(1)) ? 16384 - a : a - 16384);
                ef = 16'($urandom_range(24576, 8192));
                et = 16'($urandom_range(24576, 8192));
            end
            else
            begin
                ix = CB'($urandom);
                iy = CB'($urandom);
                nx = CB'($urandom);
                ny = CB'($urandom);
                ef = 16'($urandom);
                et = ($urandom_range(15) == 0) ? 16'h0000 : 16'($urandom);
            end
            send_ray(ix, iy, nx, ny, ef, et);
            if (i == count / 2)
                drain_results();
        end
    endtask

    // check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rays.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d", out_x, out_y);
            end
            else
            begin
                ray_result_t e;
                e = pending_rays.pop_front();
                if (out_x !== e.ox || out_y !== e.oy || total_reflection !== e.tir
                    || index_error !== e.ierr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%0d y=%0d tir=%b err=%b, ",
                                  "got x=%0d y=%0d tir=%b err=%b"},
                                 e.ox, e.oy, e.tir, e.ierr, out_x, out_y,
                                 total_reflection, index_error);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        idle_pct = 14;
        rst_n = 1'b0;
        start = 1'b0;
        dir_x = '0;
        dir_y = '0;
        normal_x = '0;
        normal_y = '0;
        index_from = '0;
        index_to = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(N_RANDOM);
        drain_results();
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_rays.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
